@@ src/tplm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the track pool lifecycle manager.
package tplm_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_AREA_RATE_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RATE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_ACT_SCALE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VALIDATE_AGE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TERMINATE_GAP   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_START_DIST      = 3'd7;

    // 50.0 square pixels in Q23.8
    localparam logic [30:0] MIN_AREA_Q8   = 31'd12800;
    // 1e6 events/s scaled to Q16 and Q24
    localparam logic [63:0] RATE_NUM_Q16  = 64'd65536000000;
    localparam logic [94:0] RATE_NUM_Q24  = 95'd16777216000000;
    // frame margins: 10 px low side, 11 px high side, Q12.4
    localparam logic signed [17:0] EDGE_LO_Q4 = 18'sd160;
    localparam logic signed [17:0] EDGE_HI_Q4 = 18'sd176;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         slot_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic [39:0]        now_time;
        logic [39:0]        last_event_time;
        logic [39:0]        start_time;
        logic [31:0]        mean_interval;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  result_slot;
        logic [31:0] unique_id;
        logic        granted;
        logic        slot_was_active;
        logic        track_deleted;
        logic        newly_validated;
        logic [15:0] new_distance_threshold;
        logic [5:0]  live_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] area_rate_gain;
        logic [31:0] base_rate_threshold;
        logic [15:0] low_activity_scale;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [39:0] validate_age;
        logic [39:0] terminate_gap;
        logic [15:0] start_distance_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        area_rate_gain:           32'd0,
        base_rate_threshold:      32'd0,
        low_activity_scale:       16'd256,
        frame_width:              12'd640,
        frame_height:             12'd480,
        validate_age:             40'd50000,
        terminate_gap:            40'd100000,
        start_distance_threshold: 16'd0
    };

    // classified item handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic [4:0]  slot_index;
        logic [31:0] mean_interval;
        logic [30:0] area;
        logic        oof;
        logic        idle;
        logic        old;
        logic        box_bad;
        logic        rate_ok;
    } t_cls;

    typedef enum logic [1:0] {
        BS_IDLE = 2'd0,
        BS_SCAN = 2'd1,
        BS_MATH = 2'd2,
        BS_DONE = 2'd3
    } t_bstate;

endpackage

@@ src/tplm_front.sv @@
`timescale 1ns / 1ps
// Front unit: accepts items, runs the stateless tests and hands classified items on.
module tplm_front
    import tplm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_push,
    output t_cls     o_push_item,
    input  logic     i_q_full
);

    logic               r_valid;
    t_cmd               r_cmd;
    logic [4:0]         r_slot;
    logic [31:0]        r_mi;
    logic               r_oof;
    logic               r_idle;
    logic               r_old;
    logic               r_bad;
    logic signed [31:0] r_p_area;
    logic [63:0]        r_bm;

    logic               w_accept;
    logic signed [40:0] w_idle_diff;
    logic signed [40:0] w_age_diff;
    logic signed [17:0] w_x;
    logic signed [17:0] w_y;
    logic signed [17:0] w_xmax;
    logic signed [17:0] w_ymax;
    logic               w_oof;
    logic signed [31:0] w_p_area;
    logic [63:0]        w_bm;
    logic [31:0]        w_abs;

    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    assign w_idle_diff = $signed({1'b0, i_in_item.now_time})
                       - $signed({1'b0, i_in_item.last_event_time});
    assign w_age_diff  = $signed({1'b0, i_in_item.now_time})
                       - $signed({1'b0, i_in_item.start_time});

    assign w_x    = 18'(i_in_item.pos_x);
    assign w_y    = 18'(i_in_item.pos_y);
    assign w_xmax = $signed({2'b00, i_cfg.frame_width, 4'b0000}) - EDGE_HI_Q4;
    assign w_ymax = $signed({2'b00, i_cfg.frame_height, 4'b0000}) - EDGE_HI_Q4;
    assign w_oof  = (w_x < EDGE_LO_Q4) || (w_x > w_xmax)
                 || (w_y < EDGE_LO_Q4) || (w_y > w_ymax);

    assign w_p_area = i_in_item.box_width * i_in_item.box_height;
    assign w_bm     = i_cfg.base_rate_threshold * i_in_item.mean_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(i_in_item.cmd);
            r_slot   <= i_in_item.slot_index;
            r_mi     <= i_in_item.mean_interval;
            r_oof    <= w_oof;
            r_idle   <= w_idle_diff > $signed({1'b0, i_cfg.terminate_gap});
            r_old    <= w_age_diff >= $signed({1'b0, i_cfg.validate_age});
            r_bad    <= (i_in_item.box_width <= 16'sd0) || (i_in_item.box_height <= 16'sd0);
            r_p_area <= w_p_area;
            r_bm     <= w_bm;
        end
    end

    // |w*h| clamped to the minimum area
    assign w_abs = r_p_area[31] ? 32'(-r_p_area) : r_p_area;

    always_comb begin
        o_push_item.cmd           = r_cmd;
        o_push_item.slot_index    = r_slot;
        o_push_item.mean_interval = r_mi;
        o_push_item.area          = (w_abs < 32'(MIN_AREA_Q8)) ? MIN_AREA_Q8 : w_abs[30:0];
        o_push_item.oof           = r_oof;
        o_push_item.idle          = r_idle;
        o_push_item.old           = r_old;
        o_push_item.box_bad       = r_bad;
        o_push_item.rate_ok       = r_bm < RATE_NUM_Q16;
    end

endmodule

@@ src/tplm_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back units.
module tplm_queue
    import tplm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_push_item,
    output logic o_full,
    output logic o_valid,
    output t_cls o_head,
    input  logic i_pop
);

    localparam int Q_PTR_W = 1;
    localparam int Q_DEPTH = 2 ** Q_PTR_W;

    t_cls               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = r_count == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

@@ src/tplm_back.sv @@
`timescale 1ns / 1ps
// Back unit: slot flags, allocation search, rate arithmetic and result register.
module tplm_back
    import tplm_pkg::*;
#(
    parameter int POOL_SLOTS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cls      i_q_item,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int SLOT_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int EXT_W   = (SLOT_W > 5) ? SLOT_W : 5;
    localparam int CNT_W   = $clog2(POOL_SLOTS + 1);
    localparam int NCHUNK  = (POOL_SLOTS + 7) / 8;
    localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FULL_W  = CH_W + 3;
    localparam logic [1:0] STEP_LAST = 2'd3;

    t_bstate             r_state;
    t_bstate             n_state;
    logic [POOL_SLOTS-1:0] r_active;
    logic [POOL_SLOTS-1:0] r_validated;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [31:0]         r_id;
    logic [CH_W-1:0]     r_chunk;
    logic [1:0]          r_step;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_cls                r_cur;
    logic [SLOT_W-1:0]   r_idx;
    logic                r_was;
    logic                r_hit;
    logic [62:0]         r_req1;
    logic [47:0]         r_floor;
    logic [62:0]         r_req;
    logic [63:0]         r_plo;
    logic [62:0]         r_phi;
    logic                r_low;

    logic                  w_pop;
    logic                  w_load;
    logic                  w_out_ready;
    logic [EXT_W-1:0]      w_head_ext;
    logic [SLOT_W-1:0]     w_head_idx;
    logic                  w_head_live;
    logic [NCHUNK*8-1:0]   w_free_pad;
    logic [7:0]            w_chunk;
    logic [2:0]            w_enc;
    logic                  w_chunk_hit;
    logic                  w_last_chunk;
    logic [FULL_W-1:0]     w_found;
    logic                  w_grant;
    logic                  w_del;
    logic                  w_val;
    t_out_item             w_res;

    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_out_ready = !r_out_valid || !i_out_stall;

    assign w_head_ext  = EXT_W'(i_q_item.slot_index);
    assign w_head_idx  = w_head_ext[SLOT_W-1:0];
    assign w_head_live = (32'(i_q_item.slot_index) < 32'(POOL_SLOTS)) && r_active[w_head_idx];

    // free map padded to whole groups of eight; padding reads as taken
    for (genvar g = 0; g < NCHUNK * 8; g++) begin : g_free
        if (g < POOL_SLOTS) begin : g_slot
            assign w_free_pad[g] = !r_active[g];
        end else begin : g_pad
            assign w_free_pad[g] = 1'b0;
        end
    end

    assign w_chunk      = w_free_pad[{r_chunk, 3'b000} +: 8];
    assign w_chunk_hit  = |w_chunk;
    assign w_last_chunk = r_chunk == CH_W'(NCHUNK - 1);
    assign w_found      = {r_chunk, w_enc};

    always_comb begin
        w_enc = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (w_chunk[k]) begin
                w_enc = 3'(k);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        w_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    w_pop = 1'b1;
                    if (i_q_item.cmd == CMD_ALLOC) begin
                        n_state = BS_SCAN;
                    end else if (i_q_item.cmd == CMD_EVAL && w_head_live) begin
                        n_state = BS_MATH;
                    end else begin
                        n_state = BS_DONE;
                    end
                end
            end
            BS_SCAN: begin
                if (w_chunk_hit || w_last_chunk) begin
                    n_state = BS_DONE;
                end
            end
            BS_MATH: begin
                if (r_step == STEP_LAST) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (w_out_ready) begin
                    w_load  = 1'b1;
                    n_state = BS_IDLE;
                end
            end
        endcase
    end

    // commit decision for the current item
    always_comb begin
        w_grant = (r_cur.cmd == CMD_ALLOC) && r_hit;
        w_del   = r_was && (r_cur.oof || (r_cur.cmd == CMD_EVAL
                  && (r_cur.idle || r_cur.box_bad || r_low)));
        w_val   = r_was && (r_cur.cmd == CMD_EVAL) && !w_del && r_cur.old
                  && r_cur.rate_ok && !r_validated[r_idx];
        n_count = r_count;
        if (w_grant) begin
            n_count = r_count + 1'b1;
        end else if (w_del) begin
            n_count = r_count - 1'b1;
        end
        w_res.result_slot            = '0;
        w_res.unique_id              = '0;
        w_res.granted                = w_grant;
        w_res.slot_was_active        = r_was;
        w_res.track_deleted          = w_del;
        w_res.newly_validated        = w_val;
        w_res.new_distance_threshold = '0;
        w_res.live_count             = 6'(n_count);
        if (w_grant) begin
            w_res.result_slot            = 5'(r_idx);
            w_res.unique_id              = r_id;
            w_res.new_distance_threshold = i_cfg.start_distance_threshold;
        end else if (r_cur.cmd == CMD_EVAL || r_cur.cmd == CMD_FRAME) begin
            w_res.result_slot = r_cur.slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_validated <= '0;
            r_count     <= '0;
            r_id        <= '0;
            r_chunk     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_chunk <= '0;
                r_step  <= '0;
            end
            if (r_state == BS_SCAN) begin
                r_chunk <= r_chunk + 1'b1;
            end
            if (r_state == BS_MATH) begin
                r_step <= r_step + 1'b1;
            end
            if (w_load) begin
                r_count <= n_count;
                if (w_grant) begin
                    r_active[r_idx]    <= 1'b1;
                    r_validated[r_idx] <= 1'b0;
                    r_id               <= r_id + 1'b1;
                end
                if (w_del) begin
                    r_active[r_idx] <= 1'b0;
                end
                if (w_val) begin
                    r_validated[r_idx] <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cur <= i_q_item;
            r_idx <= w_head_idx;
            r_was <= (i_q_item.cmd == CMD_EVAL || i_q_item.cmd == CMD_FRAME) && w_head_live;
        end
        if (r_state == BS_SCAN) begin
            r_hit <= w_chunk_hit;
            if (w_chunk_hit) begin
                r_idx <= w_found[SLOT_W-1:0];
            end
        end
        if (r_state == BS_MATH) begin
            unique case (r_step)
                2'd0: begin
                    r_req1  <= i_cfg.area_rate_gain * r_cur.area;
                    r_floor <= i_cfg.low_activity_scale * i_cfg.base_rate_threshold;
                end
                2'd1: begin
                    r_req <= (63'(r_floor) > r_req1) ? 63'(r_floor) : r_req1;
                end
                2'd2: begin
                    // required rate times interval, split into a low 32-bit and a high 31-bit part
                    r_plo <= r_req[31:0] * r_cur.mean_interval;
                    r_phi <= r_req[62:32] * r_cur.mean_interval;
                end
                2'd3: begin
                    r_low <= ({r_phi, 32'd0} + 95'(r_plo)) > RATE_NUM_Q24;
                end
            endcase
        end
        if (w_load) begin
            r_out_item <= w_res;
        end
    end

endmodule

@@ src/track_pool_lifecycle_manager_unit.sv @@
`timescale 1ns / 1ps
// Top level of the track pool lifecycle manager: configuration registers and unit wiring.
//
// Keeps active and validated bits for POOL_SLOTS track slots, the live count and the
// next unique id, and returns one result item per input item. A front unit takes an
// item, runs the frame, idle, age and shape tests and forms the area and rate products;
// a two-entry queue feeds the back unit, which owns the slot state and handles one item
// at a time. In the back unit a position check, an inactive slot or an unused command
// goes through dispatch and commit; a full check of an active slot through dispatch,
// four steps through the rate multipliers and commit; an allocate through dispatch,
// a free-slot search covering eight slots per cycle, and commit. Results sit in an
// output register, so the back unit takes the next item while a result waits but
// holds that item's commit until the register is free. Configuration is taken by a single
// write cycle and must be written only while no item is in flight.
module track_pool_lifecycle_manager_unit
    import tplm_pkg::*;
#(
    parameter int POOL_SLOTS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_item,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out_item              o_out_item,
    input  logic                   i_out_stall
);

    t_cfg r_cfg;
    logic w_push;
    t_cls w_push_item;
    logic w_q_full;
    logic w_q_valid;
    t_cls w_q_head;
    logic w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AREA_RATE_GAIN: r_cfg.area_rate_gain           <= i_cfg_data[31:0];
                REG_BASE_RATE:      r_cfg.base_rate_threshold      <= i_cfg_data[31:0];
                REG_LOW_ACT_SCALE:  r_cfg.low_activity_scale       <= i_cfg_data[15:0];
                REG_FRAME_WIDTH:    r_cfg.frame_width              <= i_cfg_data[11:0];
                REG_FRAME_HEIGHT:   r_cfg.frame_height             <= i_cfg_data[11:0];
                REG_VALIDATE_AGE:   r_cfg.validate_age             <= i_cfg_data[39:0];
                REG_TERMINATE_GAP:  r_cfg.terminate_gap            <= i_cfg_data[39:0];
                REG_START_DIST:     r_cfg.start_distance_threshold <= i_cfg_data[15:0];
            endcase
        end
    end

    tplm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .i_q_full    (w_q_full)
    );

    tplm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head),
        .i_pop       (w_q_pop)
    );

    tplm_back #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    a_count_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_item.live_count) <= 32'(POOL_SLOTS))
        else $error("live count above pool size");

    a_grant_no_eval_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.granted |->
            !o_out_item.slot_was_active && !o_out_item.track_deleted
            && !o_out_item.newly_validated)
        else $error("allocate result carries evaluate flags");

    a_eval_flags_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.track_deleted || o_out_item.newly_validated) |->
            o_out_item.slot_was_active
            && !(o_out_item.track_deleted && o_out_item.newly_validated))
        else $error("delete or validate without an active slot");

    a_queue_pop_guarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back unit popped an empty queue");

endmodule
